// File: sv/crgq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crgq_pkg
// Shared constants and codes for the counted resource grant queue.
// ----------------------------------------------------------------------------
package crgq_pkg;

  localparam int CLASS_COUNT = 4;
  localparam int QUEUE_DEPTH = 16;
  localparam int REG_COUNT   = 4;

  localparam int CLS_IDX_W = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
  localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
  localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W    = (CLASS_COUNT * QUEUE_DEPTH > 1) ?
                             $clog2(CLASS_COUNT * QUEUE_DEPTH) : 1;

  localparam int COUNT_W   = 8;
  localparam int TAG_W     = 32;
  localparam int CLASS_W   = 2;
  localparam int MODE_W    = 2;
  localparam int KIND_W    = 2;
  localparam int TDATA_W   = 40;
  localparam int PADDR_W   = 4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

  // item modes
  localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_INIT    = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_GRANT     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DROPPED   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SATURATED = 2'd2;

endpackage : crgq_pkg
`default_nettype wire

// File: sv/counted_resource_grant_queue.sv
`default_nettype none
// Latency: a result appears on the master side in the cycle after its item is
// accepted; a release handed to a waiting tag passes the tag memory read, then the output register.
// Throughput: one item per cycle while results are taken at once; a release
// with waiters holds the slave side until the tag read from memory is loaded into the output register.
// Reset: synchronous, clears counts, queue pointers, fill levels, registers;
// the tag memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// counted_resource_grant_queue
// Counting semaphore per resource class with a FIFO wait queue of request
// tags held in one synchronous memory, one region per class.
// ----------------------------------------------------------------------------
module counted_resource_grant_queue (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // slave side
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [crgq_pkg::TDATA_W-1:0] s_tdata,  // [1:0] resource_class, [33:2] request_tag
  input  wire logic [crgq_pkg::MODE_W-1:0]  s_tuser,  // [1:0] mode
  // master side
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [crgq_pkg::TDATA_W-1:0]      m_tdata,  // [1:0] granted_class, [33:2] granted_tag
  output logic [crgq_pkg::KIND_W-1:0]       m_tuser,  // [1:0] result_kind
  // configuration
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [crgq_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import crgq_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  // configuration registers
  logic [COUNT_W-1:0] init_reg [REG_COUNT];

  // per-class control state
  logic [COUNT_W-1:0] free_units [CLASS_COUNT];
  logic [QPTR_W-1:0]  queue_head [CLASS_COUNT];
  logic [QPTR_W-1:0]  queue_tail [CLASS_COUNT];
  logic [FILL_W-1:0]  queue_fill [CLASS_COUNT];

  // tag memory, one region of QUEUE_DEPTH entries per class
  logic [TAG_W-1:0]   tag_mem [CLASS_COUNT*QUEUE_DEPTH];
  logic [TAG_W-1:0]   rd_data;
  logic [CLASS_W-1:0] rd_cls;

  logic state;

  // item fields
  logic [MODE_W-1:0]  in_mode;
  logic [CLASS_W-1:0] in_cls;
  logic [TAG_W-1:0]   in_tag;
  logic [7:0]         cls_ext;
  logic [CLS_IDX_W-1:0] cls_idx;
  logic               cls_ok;
  logic               accept;
  logic               out_load;

  logic [COUNT_W-1:0] cur_free;
  logic [QPTR_W-1:0]  cur_head;
  logic [QPTR_W-1:0]  cur_tail;
  logic [FILL_W-1:0]  cur_fill;
  logic [QPTR_W-1:0]  head_inc;
  logic [QPTR_W-1:0]  tail_inc;
  logic [ADDR_W-1:0]  region_base;

  logic               mem_we;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [ADDR_W-1:0]  mem_raddr;

  logic [1:0]         cfg_idx;
  logic               cfg_we;

  assign in_mode = s_tuser;
  assign in_cls  = s_tdata[CLASS_W-1:0];
  assign in_tag  = s_tdata[CLASS_W+TAG_W-1:CLASS_W];
  assign cls_ext = {{(8-CLASS_W){1'b0}}, in_cls};
  assign cls_idx = cls_ext[CLS_IDX_W-1:0];
  assign cls_ok  = (int'(cls_ext) < CLASS_COUNT);

  // one item at a time; a waiting result is taken the same cycle or not at all
  assign s_tready = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  assign cur_free = free_units[cls_idx];
  assign cur_head = queue_head[cls_idx];
  assign cur_tail = queue_tail[cls_idx];
  assign cur_fill = queue_fill[cls_idx];

  // pointer wrap that also holds for a depth that is not a power of two
  assign head_inc = (int'(cur_head) == QUEUE_DEPTH - 1) ? '0 : cur_head + 1'b1;
  assign tail_inc = (int'(cur_tail) == QUEUE_DEPTH - 1) ? '0 : cur_tail + 1'b1;

  assign region_base = ADDR_W'(int'(cls_idx) * QUEUE_DEPTH);
  assign mem_waddr   = region_base + ADDR_W'(cur_tail);
  assign mem_raddr   = region_base + ADDR_W'(cur_head);

  // push: allocate that cannot be granted and finds room
  assign mem_we = accept && cls_ok && (in_mode == MODE_ALLOC) &&
                  !((cur_free != '0) && (cur_fill == '0)) &&
                  (int'(cur_fill) < QUEUE_DEPTH);
  // pop: release with a waiting tag
  assign mem_re = accept && cls_ok && (in_mode == MODE_RELEASE) && (cur_fill != '0);

  // output register loads: grant at once, drop on a full queue, saturated
  // release, or the tag of a waiter coming back from memory
  assign out_load = (state == ST_READ) ||
                    (accept && cls_ok && (in_mode == MODE_ALLOC) &&
                     (((cur_free != '0) && (cur_fill == '0)) ||
                      (int'(cur_fill) >= QUEUE_DEPTH))) ||
                    (accept && cls_ok && (in_mode == MODE_RELEASE) &&
                     (cur_fill == '0) && (cur_free == COUNT_MAX));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tag_mem[mem_waddr] <= in_tag;
    end
    if (mem_re) begin
      rd_data <= tag_mem[mem_raddr];
      rd_cls  <= in_cls;
    end
  end

  // APB: always ready, four byte-aligned registers
  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite;
  assign prdata  = {{(32-COUNT_W){1'b0}}, init_reg[cfg_idx]};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        init_reg[i] <= '0;
      end
    end else if (cfg_we) begin
      init_reg[cfg_idx] <= pwdata[COUNT_W-1:0];
    end
  end

  // control path
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      for (int i = 0; i < CLASS_COUNT; i++) begin
        free_units[i] <= '0;
        queue_head[i] <= '0;
        queue_tail[i] <= '0;
        queue_fill[i] <= '0;
      end
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (in_mode == MODE_INIT) begin
              for (int i = 0; i < CLASS_COUNT; i++) begin
                free_units[i] <= (i < REG_COUNT) ? init_reg[i] : '0;
                queue_head[i] <= '0;
                queue_tail[i] <= '0;
                queue_fill[i] <= '0;
              end
            end else if (cls_ok && (in_mode == MODE_ALLOC)) begin
              if ((cur_free != '0) && (cur_fill == '0)) begin
                // granted at once
                free_units[cls_idx] <= cur_free - 1'b1;
                m_tuser  <= KIND_GRANT;
                m_tdata  <= {{(TDATA_W-TAG_W-CLASS_W){1'b0}}, in_tag, in_cls};
              end else if (int'(cur_fill) >= QUEUE_DEPTH) begin
                // queue full, tag dropped
                m_tuser  <= KIND_DROPPED;
                m_tdata  <= {{(TDATA_W-TAG_W-CLASS_W){1'b0}}, in_tag, in_cls};
              end else begin
                queue_tail[cls_idx] <= tail_inc;
                queue_fill[cls_idx] <= cur_fill + 1'b1;
              end
            end else if (cls_ok && (in_mode == MODE_RELEASE)) begin
              if (cur_fill != '0) begin
                // oldest waiter gets the unit; tag comes back next cycle
                queue_head[cls_idx] <= head_inc;
                queue_fill[cls_idx] <= cur_fill - 1'b1;
                state <= ST_READ;
              end else if (cur_free == COUNT_MAX) begin
                m_tuser  <= KIND_SATURATED;
                m_tdata  <= {{(TDATA_W-CLASS_W){1'b0}}, in_cls};
              end else begin
                free_units[cls_idx] <= cur_free + 1'b1;
              end
            end
            // unused mode or class out of range: no effect
          end
        end
        ST_READ: begin
          // output register is free here: it was empty or drained at accept
          m_tuser  <= KIND_GRANT;
          m_tdata  <= {{(TDATA_W-TAG_W-CLASS_W){1'b0}}, rd_data, rd_cls};
          state    <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule : counted_resource_grant_queue
`default_nettype wire
